// ----- src/lr_pkg.sv -----
// Shared types, constants and helpers of the line rasterizer.
package lr_pkg;

	localparam int GRID_SIZE = 64;
	localparam int COORD_W   = 6;
	localparam int COLOR_W   = 32;
	localparam int DEC_W     = 9;

	typedef logic [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t               start_x;
		coord_t               start_y;
		coord_t               end_x;
		coord_t               end_y;
		logic [COLOR_W-1:0]   color;
	} line_seg_t;

	typedef struct packed {
		coord_t               pixel_x;
		coord_t               pixel_y;
		logic [COLOR_W-1:0]   pixel_color;
		logic                 last;
	} line_pix_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_EMIT
	} lr_state_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic advance;
	} lr_cmd_t;

	typedef struct packed {
		logic at_end;
	} lr_status_t;

	// Saturate a coordinate to the last grid column or row.
	function automatic coord_t clamp_coord(input coord_t v);
		coord_t r;
		if ({1'b0, v} >= (COORD_W+1)'(GRID_SIZE)) begin
			r = COORD_W'(GRID_SIZE - 1);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ----- src/line_rasterizer_unit.sv -----
// Top level of the line rasterizer: controller plus datapath.
//
// Channel   Direction  Handshake              Payload
// segment   in         start & !busy          seg   (line_seg_t)
// pixel     out        strobe, one cycle      pixel (line_pix_t)
//
// A segment of n = max(|dx|, |dy|) + 1 pixels (at most 64 on a 64-wide grid)
// goes from its accept through a load, then a setup of the deltas and the
// decision variable, then one pixel per cycle from the single step unit.
// busy is high from the cycle after the accept through the final pixel.
// Reset clears the controller to idle; datapath registers need no reset.
// The receiver cannot stall: each pixel shows for exactly one cycle.
module line_rasterizer_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  lr_pkg::line_seg_t seg,
	output logic              busy,
	output logic              strobe,
	output lr_pkg::line_pix_t pixel
);
	import lr_pkg::*;

	lr_cmd_t    cmd;
	lr_status_t status;

	// sequence load, setup and one step per emitted pixel but the final one
	lr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.strobe (strobe)
	);

	// hold the segment and walk its pixels
	lr_datapath u_datapath (
		.clk    (clk),
		.seg    (seg),
		.cmd    (cmd),
		.status (status),
		.pixel  (pixel)
	);

`ifndef SYNTHESIS
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("pixel strobe while idle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !strobe))
		else $error("accepted item did not enter setup");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && pixel.last) |=> (!strobe && !busy))
		else $error("pixel emitted after the final pixel");

	a_run_on: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !pixel.last) |=> strobe)
		else $error("pixel run broke before the final pixel");
`endif

endmodule

// ----- src/lr_ctrl.sv -----
// Controller state machine of the line rasterizer.
module lr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  lr_pkg::lr_status_t status,
	output lr_pkg::lr_cmd_t    cmd,
	output logic               busy,
	output logic               strobe
);
	import lr_pkg::*;

	lr_state_t state_q;
	lr_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd.load    = 1'b0;
		cmd.setup   = 1'b0;
		cmd.advance = 1'b0;
		busy        = 1'b1;
		strobe      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				strobe = 1'b1;
				// drop back to idle after the final pixel, else advance
				if (status.at_end) begin
					state_d = ST_IDLE;
				end else begin
					cmd.advance = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- src/lr_datapath.sv -----
// Datapath of the line rasterizer: coordinates, deltas and decision variable.
module lr_datapath (
	input  logic              clk,
	input  lr_pkg::line_seg_t seg,
	input  lr_pkg::lr_cmd_t   cmd,
	output lr_pkg::lr_status_t status,
	output lr_pkg::line_pix_t pixel
);
	import lr_pkg::*;

	coord_t                   cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
	coord_t                   major_q, minor_q;
	logic [COLOR_W-1:0]       color_q;
	logic signed [DEC_W-1:0]  dec_q;
	logic                     x_neg_q, y_neg_q, x_major_q;

	logic                     x_neg, y_neg;
	coord_t                   adx, ady, major, minor;
	logic                     x_major;
	logic signed [DEC_W-1:0]  two_minor, two_major;
	logic                     minor_step;
	logic                     at_end;

	// setup arithmetic from the loaded end points
	always_comb begin
		x_neg   = tgt_x_q < cur_x_q;
		y_neg   = tgt_y_q < cur_y_q;
		adx     = x_neg ? (cur_x_q - tgt_x_q) : (tgt_x_q - cur_x_q);
		ady     = y_neg ? (cur_y_q - tgt_y_q) : (tgt_y_q - cur_y_q);
		x_major = adx > ady;
		major   = x_major ? adx : ady;
		minor   = x_major ? ady : adx;
	end

	assign two_minor  = {2'b00, minor_q, 1'b0};
	assign two_major  = {2'b00, major_q, 1'b0};
	assign minor_step = !dec_q[DEC_W-1];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_x_q <= clamp_coord(seg.start_x);
			cur_y_q <= clamp_coord(seg.start_y);
			tgt_x_q <= clamp_coord(seg.end_x);
			tgt_y_q <= clamp_coord(seg.end_y);
			color_q <= seg.color;
		end
		if (cmd.setup) begin
			x_neg_q   <= x_neg;
			y_neg_q   <= y_neg;
			x_major_q <= x_major;
			major_q   <= major;
			minor_q   <= minor;
			dec_q     <= $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
		end
		if (cmd.advance) begin
			if (minor_step) begin
				dec_q <= dec_q + two_minor - two_major;
			end else begin
				dec_q <= dec_q + two_minor;
			end
			if (x_major_q || minor_step) begin
				cur_x_q <= x_neg_q ? (cur_x_q - coord_t'(1)) : (cur_x_q + coord_t'(1));
			end
			if (!x_major_q || minor_step) begin
				cur_y_q <= y_neg_q ? (cur_y_q - coord_t'(1)) : (cur_y_q + coord_t'(1));
			end
		end
	end

	// the major coordinate reaching its target marks the final pixel
	assign at_end = x_major_q ? (cur_x_q == tgt_x_q) : (cur_y_q == tgt_y_q);

	assign status.at_end     = at_end;
	assign pixel.pixel_x     = cur_x_q;
	assign pixel.pixel_y     = cur_y_q;
	assign pixel.pixel_color = color_q;
	assign pixel.last        = at_end;

endmodule

// ----- dv/tb_line_rasterizer_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for line_rasterizer_unit: directed and random segments.
module tb_line_rasterizer_unit;
	import lr_pkg::*;

	// Cycles with neither an accepted item nor an owed pixel before the run is declared hung.
	// Within a segment only the setup cycle is silent, so only sender gaps matter.
	localparam int QUIET_LIMIT = 2000;
	// Cycles to wait after the last expected pixel, to catch stray strobes.
	localparam int DRAIN_CYCLES = 8;
	// Random items per idling phase.
	localparam int ITEMS_PER_PHASE = 107;
	localparam int N_DIRECTED = 24;

	// One row of the directed table. When typed is set, the segment must give a single
	// pixel at (want_x, want_y) with last high; otherwise the predictor supplies the pixels.
	typedef struct packed {
		logic       typed;
		coord_t     sx;
		coord_t     sy;
		coord_t     ex;
		coord_t     ey;
		logic [31:0] color;
		coord_t     want_x;
		coord_t     want_y;
	} dir_row_t;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	line_seg_t seg = '0;
	logic      busy;
	logic      strobe;
	line_pix_t pixel;

	// Pixels still owed by the block, oldest first.
	line_pix_t   pending_pixels[$];
	int unsigned pixel_faults = 0;
	int unsigned quiet_cycles = 0;
	// Percentage of cycles in which the sender holds off before offering an item.
	int unsigned idle_pct = 0;

	// Directed segments: the zero-length corners are typed in; the rest are full-length
	// rows and columns, the four diagonals, one segment per octant, the unit steps and a 2:1 step.
	dir_row_t dir_table [0:N_DIRECTED-1] = '{
		'{1'b1, 6'd0,  6'd0,  6'd0,  6'd0,  32'h0000_0000, 6'd0,  6'd0},
		'{1'b1, 6'd63, 6'd63, 6'd63, 6'd63, 32'hFFFF_FFFF, 6'd63, 6'd63},
		'{1'b1, 6'd0,  6'd63, 6'd0,  6'd63, 32'hA5A5_A5A5, 6'd0,  6'd63},
		'{1'b1, 6'd63, 6'd0,  6'd63, 6'd0,  32'h5A5A_5A5A, 6'd63, 6'd0},
		'{1'b0, 6'd0,  6'd0,  6'd63, 6'd0,  32'h1234_5678, 6'd0,  6'd0},
		'{1'b0, 6'd63, 6'd5,  6'd0,  6'd5,  32'h8765_4321, 6'd0,  6'd0},
		'{1'b0, 6'd7,  6'd0,  6'd7,  6'd63, 32'hFFFF_0000, 6'd0,  6'd0},
		'{1'b0, 6'd7,  6'd63, 6'd7,  6'd0,  32'h0000_FFFF, 6'd0,  6'd0},
		'{1'b0, 6'd0,  6'd0,  6'd63, 6'd63, 32'h5555_5555, 6'd0,  6'd0},
		'{1'b0, 6'd63, 6'd63, 6'd0,  6'd0,  32'hAAAA_AAAA, 6'd0,  6'd0},
		'{1'b0, 6'd63, 6'd0,  6'd0,  6'd63, 32'hFF00_FF00, 6'd0,  6'd0},
		'{1'b0, 6'd0,  6'd63, 6'd63, 6'd0,  32'h00FF_00FF, 6'd0,  6'd0},
		'{1'b0, 6'd10, 6'd10, 6'd30, 6'd13, 32'hDEAD_BEEF, 6'd0,  6'd0},
		'{1'b0, 6'd30, 6'd10, 6'd10, 6'd13, 32'hCAFE_F00D, 6'd0,  6'd0},
		'{1'b0, 6'd10, 6'd13, 6'd30, 6'd10, 32'h0BAD_F00D, 6'd0,  6'd0},
		'{1'b0, 6'd30, 6'd13, 6'd10, 6'd10, 32'hFEED_FACE, 6'd0,  6'd0},
		'{1'b0, 6'd10, 6'd10, 6'd13, 6'd30, 32'h0F0F_0F0F, 6'd0,  6'd0},
		'{1'b0, 6'd10, 6'd10, 6'd7,  6'd30, 32'hF0F0_F0F0, 6'd0,  6'd0},
		'{1'b0, 6'd10, 6'd30, 6'd13, 6'd10, 32'h3C3C_3C3C, 6'd0,  6'd0},
		'{1'b0, 6'd10, 6'd30, 6'd7,  6'd10, 32'hC3C3_C3C3, 6'd0,  6'd0},
		'{1'b0, 6'd5,  6'd5,  6'd6,  6'd6,  32'h0000_0001, 6'd0,  6'd0},
		'{1'b0, 6'd5,  6'd5,  6'd6,  6'd5,  32'h8000_0000, 6'd0,  6'd0},
		'{1'b0, 6'd5,  6'd5,  6'd5,  6'd4,  32'h7FFF_FFFF, 6'd0,  6'd0},
		'{1'b0, 6'd20, 6'd20, 6'd22, 6'd21, 32'h0000_00FF, 6'd0,  6'd0}
	};

	line_rasterizer_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.seg    (seg),
		.busy   (busy),
		.strobe (strobe),
		.pixel  (pixel)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Saturate a coordinate that lies past the grid to its last row or column.
	function automatic int sat_coord(input coord_t v);
		return (int'(v) >= GRID_SIZE) ? GRID_SIZE - 1 : int'(v);
	endfunction

	function automatic line_pix_t make_pix(input int x, input int y, input logic [31:0] c,
			input logic lst);
		line_pix_t p;
		p.pixel_x     = coord_t'(x);
		p.pixel_y     = coord_t'(y);
		p.pixel_color = c;
		p.last        = lst;
		return p;
	endfunction

	// Append one pixel to the tail of the owed list.
	function automatic void owe_pixel(input line_pix_t p);
		pending_pixels.insert(pending_pixels.size(), p);
	endfunction

	// Walk the segment by the midpoint rule and queue every pixel it covers.
	// The decision term is kept doubled; ties in |dx| and |dy| go to the y axis.
	task automatic trace_segment(input line_seg_t s);
		int x, y, tx, ty, dx, dy, step_x, step_y;
		int major, minor, decision, n;
		bit x_major;
		x  = sat_coord(s.start_x);
		y  = sat_coord(s.start_y);
		tx = sat_coord(s.end_x);
		ty = sat_coord(s.end_y);
		dx = tx - x;
		dy = ty - y;
		// A flat axis steps positive but never moves.
		step_x  = (dx < 0) ? -1 : 1;
		step_y  = (dy < 0) ? -1 : 1;
		x_major = (dx * step_x) > (dy * step_y);
		major   = x_major ? dx * step_x : dy * step_y;
		minor   = x_major ? dy * step_y : dx * step_x;
		decision = 2 * minor - major;
		owe_pixel(make_pix(x, y, s.color, x == tx && y == ty));
		n = 1;
		while (n < 64 && (x_major ? x != tx : y != ty)) begin
			if (x_major) x += step_x; else y += step_y;
			if (decision < 0) begin
				decision += 2 * minor;
			end else begin
				decision += 2 * minor - 2 * major;
				if (x_major) y += step_y; else x += step_x;
			end
			owe_pixel(make_pix(x, y, s.color, x_major ? x == tx : y == ty));
			n++;
		end
	endtask

	// Offer one item after a random hold-off, keep start high until the block takes it,
	// then queue what it must emit. start stays high so the next item can follow at once.
	task automatic send_segment(input line_seg_t s, input bit typed, input line_pix_t want);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		seg   <= s;
		do @(posedge clk); while (busy !== 1'b0);
		if (typed) owe_pixel(want);
		else trace_segment(s);
	endtask

	// Pick a random coordinate within reach of a start point, clipped to the grid.
	function automatic coord_t near_coord(input coord_t c, input int reach);
		int v;
		v = int'(c) + int'($urandom_range(2 * reach)) - reach;
		if (v < 0) v = 0;
		if (v > GRID_SIZE - 1) v = GRID_SIZE - 1;
		return coord_t'(v);
	endfunction

	// Compare each pixel with the oldest one owed; check every field.
	always @(posedge clk) begin
		line_pix_t want;
		if (arst_n && strobe === 1'b1) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected pixel x=%0d y=%0d color=%h last=%b",
					pixel.pixel_x, pixel.pixel_y, pixel.pixel_color, pixel.last);
				pixel_faults++;
			end else begin
				want = pending_pixels.pop_front();
				if (pixel.pixel_x !== want.pixel_x) begin
					$error("pixel_x expected %0d got %0d", want.pixel_x, pixel.pixel_x);
					pixel_faults++;
				end
				if (pixel.pixel_y !== want.pixel_y) begin
					$error("pixel_y expected %0d got %0d", want.pixel_y, pixel.pixel_y);
					pixel_faults++;
				end
				if (pixel.pixel_color !== want.pixel_color) begin
					$error("pixel_color expected %h got %h", want.pixel_color,
						pixel.pixel_color);
					pixel_faults++;
				end
				if (pixel.last !== want.last) begin
					$error("last expected %b got %b", want.last, pixel.last);
					pixel_faults++;
				end
			end
		end
	end

	// Watchdog: restart the count on any accepted item or owed pixel; give up when it
	// runs out. Stray strobes with nothing owed do not count as progress.
	always @(posedge clk) begin
		if (!arst_n || (start && busy === 1'b0) ||
				(strobe === 1'b1 && pending_pixels.size() != 0)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("line_rasterizer_unit regression: fail");
				$finish;
			end
		end
	end

	initial begin
		line_seg_t   s;
		line_pix_t   want;
		int unsigned kind;
		// Sender hold-off per phase. The receiver cannot stall, so the phase meant for
		// receiver stalls runs with no idling and the combined phase keeps only sender gaps.
		int unsigned phase_idle [4];

		phase_idle = '{0, 64, 0, 19};

		// Hold reset, then release it on an edge.
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, back to back.
		for (int i = 0; i < N_DIRECTED; i++) begin
			s.start_x = dir_table[i].sx;
			s.start_y = dir_table[i].sy;
			s.end_x   = dir_table[i].ex;
			s.end_y   = dir_table[i].ey;
			s.color   = dir_table[i].color;
			want = make_pix(dir_table[i].want_x, dir_table[i].want_y, dir_table[i].color, 1'b1);
			send_segment(s, dir_table[i].typed, want);
		end

		// Random part: mostly short segments and full-range ones, a few single points.
		foreach (phase_idle[ph]) begin
			idle_pct = phase_idle[ph];
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				kind      = $urandom_range(9);
				s.start_x = coord_t'($urandom_range(GRID_SIZE - 1));
				s.start_y = coord_t'($urandom_range(GRID_SIZE - 1));
				s.color   = $urandom;
				if (kind == 0) begin
					s.end_x = s.start_x;
					s.end_y = s.start_y;
				end else if (kind <= 4) begin
					s.end_x = near_coord(s.start_x, 7);
					s.end_y = near_coord(s.start_y, 7);
				end else begin
					s.end_x = coord_t'($urandom_range(GRID_SIZE - 1));
					s.end_y = coord_t'($urandom_range(GRID_SIZE - 1));
				end
				send_segment(s, 1'b0, want);
			end
		end
		start <= 1'b0;

		// Drain: the watchdog ends the run if owed pixels never show.
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pixel_faults == 0) begin
			$display("line_rasterizer_unit regression: pass");
		end else begin
			$display("line_rasterizer_unit regression: fail");
		end
		$finish;
	end

endmodule
